// ===== hw/rtl/pidl_pkg.sv =====
package pidl_pkg;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_GET    = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  // Fixed field widths of the ports.
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [1:0]         mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } out_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] fill;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/pidl_cell.sv =====
module pidl_cell #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = 32
) (
  input  logic                    clk,
  input  pidl_pkg::cell_ctrl_t    ctrl,
  input  logic [WORD_WIDTH-1:0]   ins_word,
  input  logic [WORD_WIDTH-1:0]   left,
  input  logic [WORD_WIDTH-1:0]   right,
  output logic [WORD_WIDTH-1:0]   word,
  output logic [WORD_WIDTH-1:0]   sel_word
);

  logic at_pos;
  logic above_pos;
  logic in_ins_span;
  logic in_del_span;

  // Position decode against this cell's fixed index.
  assign at_pos      = (IDX == int'(ctrl.pos));
  assign above_pos   = (IDX > int'(ctrl.pos));
  assign in_ins_span = above_pos && (IDX <= int'(ctrl.fill));
  assign in_del_span = (at_pos || above_pos) && (IDX + 1 < int'(ctrl.fill));

  // Insert takes the new word or the lower neighbor; delete takes the upper neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (at_pos) begin
        word <= ins_word;
      end else if (in_ins_span) begin
        word <= left;
      end
    end else if (ctrl.del) begin
      if (in_del_span) begin
        word <= right;
      end
    end
  end

  // Only the addressed cell drives its word onto the read bus.
  assign sel_word = at_pos ? word : '0;

endmodule

// ===== hw/rtl/positional_insert_delete_list_core.sv =====
// Positional insert/delete list held in a chain of word cells.
// Input channel in_valid/in_ready/in_data carries one word per operation:
// insert, delete, get or clear at a position. Output channel
// out_valid/out_ready/out_data returns one word per operation with the
// read value, the status and the list length after the operation.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the capacity;
// it is always ready and should be written only while the block is idle.
// The result word is registered at the edge that accepts the operation.
// One operation is taken per cycle while the receiver keeps taking
// results, since all cells shift in parallel in the accepting cycle and
// the result register frees itself when it is taken in the same cycle.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken.
// Reset clears the length to zero and the capacity to the built depth,
// capped at 127. Entry contents are not cleared; an entry is only read
// after an insert wrote it, so no clearing pass runs after reset.
module positional_insert_delete_list_core #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pidl_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pidl_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [pidl_pkg::COUNT_W-1:0] cfg_data
);

  localparam int CW = pidl_pkg::COUNT_W;
  localparam int CNT_MAX = (1 << CW) - 1;
  localparam logic [CW-1:0] DEPTH_CAP = (DEPTH > CNT_MAX) ? CW'(CNT_MAX) : CW'(DEPTH);

  logic [CW-1:0]         capacity;
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  logic [CW-1:0]         cap_eff;
  logic [CW-1:0]         pos_ext;
  logic [WORD_WIDTH-1:0] val_w;
  logic [WORD_WIDTH-1:0] rd_bus;
  logic [pidl_pkg::VALUE_W-1:0] rd_ext;
  logic                  accept;
  logic                  ins_ok;
  logic                  del_ok;
  pidl_pkg::out_word_t   res;
  pidl_pkg::cell_ctrl_t  ctrl;

  logic [WORD_WIDTH-1:0] cell_word [DEPTH];
  logic [WORD_WIDTH-1:0] cell_sel  [DEPTH];

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign cap_eff = (capacity > DEPTH_CAP) ? DEPTH_CAP : capacity;
  assign pos_ext = CW'(in_data.position);

  // Fit the 32-bit value into the stored word width.
  always_comb begin
    val_w = '0;
    for (int b = 0; b < WORD_WIDTH; b++) begin
      if (b < pidl_pkg::VALUE_W) begin
        val_w[b] = in_data.value[5'(b)];
      end
    end
  end

  // Read bus: only the addressed cell contributes.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_sel[i];
    end
  end

  always_comb begin
    rd_ext = '0;
    for (int b = 0; b < pidl_pkg::VALUE_W; b++) begin
      if (b < WORD_WIDTH) begin
        rd_ext[b] = rd_bus[b];
      end
    end
  end

  // Operation checks, length update and result word.
  always_comb begin
    ins_ok         = 1'b0;
    del_ok         = 1'b0;
    fill_next      = fill;
    res.read_value = '0;
    res.status     = pidl_pkg::ST_OK;
    unique case (in_data.mode)
      pidl_pkg::MODE_INSERT: begin
        if (val_w == '0) begin
          res.status = pidl_pkg::ST_ZERO;
        end else if (pos_ext >= cap_eff) begin
          res.status = pidl_pkg::ST_BAD_POS;
        end else if (fill >= cap_eff) begin
          res.status = pidl_pkg::ST_FULL;
        end else if (pos_ext > fill) begin
          res.status = pidl_pkg::ST_BAD_POS;
        end else begin
          ins_ok    = 1'b1;
          fill_next = fill + CW'(1);
        end
      end
      pidl_pkg::MODE_DELETE: begin
        if (pos_ext >= fill) begin
          res.status = pidl_pkg::ST_BAD_POS;
        end else begin
          del_ok    = 1'b1;
          fill_next = fill - CW'(1);
        end
      end
      pidl_pkg::MODE_GET: begin
        if (pos_ext >= fill) begin
          res.status = pidl_pkg::ST_BAD_POS;
        end else begin
          res.read_value = rd_ext;
        end
      end
      pidl_pkg::MODE_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        fill_next = fill;
      end
    endcase
    res.count = fill_next;
  end

  // Command for the cell chain, active only in the accepting cycle.
  assign ctrl.ins  = accept && ins_ok;
  assign ctrl.del  = accept && del_ok;
  assign ctrl.pos  = pos_ext;
  assign ctrl.fill = fill;

  // Chain of cells, each wired to its lower and upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = val_w;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    pidl_cell #(
      .IDX        (i),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ins_word (val_w),
      .left     (left_w),
      .right    (right_w),
      .word     (cell_word[i]),
      .sel_word (cell_sel[i])
    );
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= DEPTH_CAP;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Length and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule

// ===== hw/rtl/pidl_chk.sv =====
module pidl_chk #(
  parameter int DEPTH = 64
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pidl_pkg::out_word_t out_data
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // No new word is taken while the result register is held.
  a_in_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Every accepted word yields a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after accepted word");

  // A failed operation never returns data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != pidl_pkg::ST_OK |-> out_data.read_value == '0)
    else $error("data returned with error status");

  // The length never exceeds the built depth.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(out_data.count) <= DEPTH)
    else $error("length exceeds depth");

endmodule

bind positional_insert_delete_list_core pidl_chk #(.DEPTH(DEPTH)) u_pidl_chk (.*);

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int LIST_DEPTH = 64;
  localparam int STUCK_LIMIT = 3000;
  localparam int NUM_PHASES = 7;
  localparam int CW = pidl_pkg::COUNT_W;
  localparam int PW = pidl_pkg::POS_W;
  localparam int VW = pidl_pkg::VALUE_W;

  typedef enum bit {ROW_OP, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SKIP, RX_SPARSE} rx_mode_t;

  // One line of the directed plan: either a capacity write or a list word,
  // with a hand-written result where it is obvious.
  typedef struct packed {
    row_kind_t           kind;
    logic [CW-1:0]       cap;
    pidl_pkg::in_word_t  op;
    bit                  typed;
    pidl_pkg::out_word_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd0,  32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd0}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_DELETE, 6'd0,  32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd0}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd63, 32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_ZERO, 7'd0}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd1,  32'h1234},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd0}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd0,  32'hFFFFFFFF},
      1'b1, '{32'h0, pidl_pkg::ST_OK, 7'd1}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd0,  32'h0},
      1'b1, '{32'hFFFFFFFF, pidl_pkg::ST_OK, 7'd1}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd1,  32'h1},
      1'b1, '{32'h0, pidl_pkg::ST_OK, 7'd2}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd0,  32'hA5A5A5A5},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd1,  32'h5A5A5A5A},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd63, 32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd4}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd3,  32'hFFFFFFFF},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_DELETE, 6'd1,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd1,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_DELETE, 6'd2,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd2,  32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd2}},
    '{ROW_CFG, 7'd1,   '{pidl_pkg::MODE_CLEAR,  6'd0,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd0,  32'h77},
      1'b1, '{32'h0, pidl_pkg::ST_FULL, 7'd2}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd1,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_DELETE, 6'd0,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd1,  32'h55},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd1}},
    '{ROW_CFG, 7'd0,   '{pidl_pkg::MODE_CLEAR,  6'd0,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd0,  32'h99},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd1}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_CLEAR,  6'd0,  32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_OK, 7'd0}},
    '{ROW_CFG, 7'd127, '{pidl_pkg::MODE_CLEAR,  6'd0,  32'h0},
      1'b0, '0},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_INSERT, 6'd0,  32'h80000000},
      1'b1, '{32'h0, pidl_pkg::ST_OK, 7'd1}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_CLEAR,  6'd63, 32'hFFFFFFFF},
      1'b1, '{32'h0, pidl_pkg::ST_OK, 7'd0}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_CLEAR,  6'd0,  32'h0},
      1'b1, '{32'h0, pidl_pkg::ST_OK, 7'd0}},
    '{ROW_OP,  7'd0,   '{pidl_pkg::MODE_GET,    6'd0,  32'h12345678},
      1'b1, '{32'h0, pidl_pkg::ST_BAD_POS, 7'd0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pidl_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pidl_pkg::out_word_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CW-1:0]       cfg_data = '0;

  // Shadow copy of the list, its length and the capacity register.
  logic [VW-1:0] list_mem [LIST_DEPTH];
  int            list_len = 0;
  logic [CW-1:0] cap_reg = CW'(LIST_DEPTH);

  pidl_pkg::out_word_t pending_results [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cfg_writes = 0;
  int        mode_seen [4] = '{0, 0, 0, 0};
  int        full_rejects = 0;
  int        peak_len = 0;
  int        burst_left = 0;
  int        stuck_cycles = 0;

  rx_mode_t  rx_mode = RX_OPEN;
  int        rx_seg_left = 0;
  logic [2:0] rx_phase = '0;

  positional_insert_delete_list_core #(
    .DEPTH(LIST_DEPTH),
    .WORD_WIDTH(VW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one list operation to the shadow state and return its result word.
  function automatic pidl_pkg::out_word_t apply_list_op(pidl_pkg::in_word_t w);
    pidl_pkg::out_word_t r;
    int lim;
    int p;
    int i;
    r = '0;
    r.status = pidl_pkg::ST_OK;
    lim = (int'(cap_reg) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
    p = int'(w.position);
    case (w.mode)
      pidl_pkg::MODE_INSERT: begin
        if (w.value == '0) begin
          r.status = pidl_pkg::ST_ZERO;
        end else if (p >= lim) begin
          r.status = pidl_pkg::ST_BAD_POS;
        end else if (list_len >= lim) begin
          r.status = pidl_pkg::ST_FULL;
          full_rejects++;
        end else if (p > list_len) begin
          r.status = pidl_pkg::ST_BAD_POS;
        end else begin
          for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = w.value;
          list_len++;
        end
      end
      pidl_pkg::MODE_DELETE: begin
        if (p >= list_len) begin
          r.status = pidl_pkg::ST_BAD_POS;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      pidl_pkg::MODE_GET: begin
        if (p >= list_len) begin
          r.status = pidl_pkg::ST_BAD_POS;
        end else begin
          r.read_value = list_mem[p];
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    if (list_len > peak_len) peak_len = list_len;
    r.count = CW'(list_len);
    return r;
  endfunction

  // Offer one word, record its result when it is taken, then pace the
  // sender in bursts with gaps of random length.
  task automatic send_word(pidl_pkg::in_word_t w, bit typed, pidl_pkg::out_word_t want);
    pidl_pkg::out_word_t r;
    int gap;
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = apply_list_op(w);
    mode_seen[w.mode]++;
    pending_results.push_back(typed ? want : r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Change the capacity only once the block has drained.
  task automatic write_capacity(logic [CW-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: switches among stall patterns in segments of random length.
  always @(posedge clk) begin
    if (rx_seg_left == 0) begin
      rx_mode     <= rx_mode_t'($urandom_range(0, 3));
      rx_seg_left <= $urandom_range(16, 64);
    end else begin
      rx_seg_left <= rx_seg_left - 1;
    end
    rx_phase <= rx_phase + 3'd1;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SKIP:   out_ready <= (rx_phase[1:0] != 2'd0);
      default:   out_ready <= (rx_phase == 3'd0);
    endcase
  end

  // Compare every result word taken with the oldest one still owed.
  always @(posedge clk) begin : check_results
    pidl_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: value %h status %0d count %0d",
                   out_data.read_value, out_data.status, out_data.count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value || out_data.status !== want.status ||
            out_data.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch on result %0d: expected value %h status %0d count %0d, %s",
                     results_seen, want.read_value, want.status, want.count,
                     $sformatf("got value %h status %0d count %0d",
                               out_data.read_value, out_data.status, out_data.count));
        end
      end
    end
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("No handshake for %0d cycles", STUCK_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : main_seq
    logic [CW-1:0] phase_cap [NUM_PHASES];
    int phase_len [NUM_PHASES];
    int phase_ins [NUM_PHASES];
    int phase_del [NUM_PHASES];
    int phase_clr [NUM_PHASES];
    pidl_pkg::in_word_t w;
    int roll;
    int top;
    phase_cap = '{7'd64, 7'd127, 7'd5, 7'd0, 7'd1, 7'd0, 7'd64};
    phase_len = '{120, 60, 50, 20, 30, 60, 60};
    phase_ins = '{85, 40, 40, 40, 45, 50, 55};
    phase_del = '{5, 30, 30, 20, 25, 25, 20};
    phase_clr = '{0, 3, 5, 10, 5, 3, 2};
    phase_cap[5] = CW'($urandom_range(2, 63));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan: corner cases, most with hand-written results.
    foreach (PLAN[k]) begin
      if (PLAN[k].kind == ROW_CFG)
        write_capacity(PLAN[k].cap);
      else
        send_word(PLAN[k].op, PLAN[k].typed, PLAN[k].want);
    end

    // Random phases, mostly well-formed positions so the list grows deep.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_cap[ph]);
      for (int n = 0; n < phase_len[ph]; n++) begin
        roll = $urandom_range(0, 99);
        w.value = $urandom;
        w.position = PW'($urandom_range(0, 63));
        if (roll < phase_ins[ph]) begin
          w.mode = pidl_pkg::MODE_INSERT;
          top = (list_len > 63) ? 63 : list_len;
          if ($urandom_range(0, 99) < 85) w.position = PW'($urandom_range(0, top));
          roll = $urandom_range(0, 99);
          if (roll < 5) w.value = '0;
          else if (roll < 8) w.value = '1;
          else if (roll < 10) w.value = 32'h1;
        end else if (roll < phase_ins[ph] + phase_del[ph]) begin
          w.mode = pidl_pkg::MODE_DELETE;
          if (list_len > 0 && $urandom_range(0, 99) < 80)
            w.position = PW'($urandom_range(0, list_len - 1));
        end else if (roll < 100 - phase_clr[ph]) begin
          w.mode = pidl_pkg::MODE_GET;
          if (list_len > 0 && $urandom_range(0, 99) < 80)
            w.position = PW'($urandom_range(0, list_len - 1));
        end else begin
          w.mode = pidl_pkg::MODE_CLEAR;
        end
        send_word(w, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d list words (%0d insert, %0d delete, %0d get, %0d clear), %0d results.",
             mode_seen[pidl_pkg::MODE_INSERT] + mode_seen[pidl_pkg::MODE_DELETE] +
             mode_seen[pidl_pkg::MODE_GET] + mode_seen[pidl_pkg::MODE_CLEAR],
             mode_seen[pidl_pkg::MODE_INSERT], mode_seen[pidl_pkg::MODE_DELETE],
             mode_seen[pidl_pkg::MODE_GET], mode_seen[pidl_pkg::MODE_CLEAR], results_seen);
    $display("Capacity written %0d times; longest list %0d, full-list rejections %0d.",
             cfg_writes, peak_len, full_rejects);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, pending_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== positional_insert_delete_list_core.f =====
hw/rtl/pidl_pkg.sv
hw/rtl/pidl_cell.sv
hw/rtl/positional_insert_delete_list_core.sv
hw/rtl/pidl_chk.sv
dv/tb_top.sv
